[rtl/sips_pkg.sv]
// Shared codes and types for the sorted insert priority stack.
// No dependencies; imported by sips_cell and sorted_insert_priority_stack.
package sips_pkg;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } sips_ctl_t;

endpackage

[rtl/sips_cell.sv]
// One slot of the ordered store: holds an entry and shifts with its neighbors.
// Depends on sips_pkg for the control struct.
module sips_cell import sips_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  sips_ctl_t             ctl,
  input  logic                  valid,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] prev_entry,
  input  logic                  prev_le,
  input  logic [DATA_WIDTH-1:0] next_entry,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  le
);

  logic [DATA_WIDTH-1:0] entry_next;

  assign le = valid && ($signed(entry) <= $signed(din));

  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      if (!le) begin
        entry_next = prev_le ? din : prev_entry;
      end
    end else if (ctl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[rtl/sorted_insert_priority_stack.sv]
// Top level of the sorted insert priority stack: a row of sips_cell slots,
// the fill count and the result registers. Depends on sips_pkg and sips_cell.
//
//   channel   handshake              fields
//   input     start & !busy          mode, value
//   result    done (one cycle)       top_value, item_count, is_empty, status
//
// One item per cycle; busy stays low. The result shows in the cycle after
// the item is taken, set by the shift of the cell row.
// Reset clears the count and the result strobe; slot contents stay as they are.
// The receiver cannot stall: done is a one-cycle strobe.
module sorted_insert_priority_stack import sips_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [MODE_W-1:0]                mode,
  input  logic signed [FIELD_W-1:0]        value,
  output logic                             done,
  output logic signed [FIELD_W-1:0]        top_value,
  output logic [$clog2(DEPTH+1)-1:0]       item_count,
  output logic                             is_empty,
  output logic [STATUS_W-1:0]              status
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [STATUS_W-1:0]   status_next;
  logic                  full;
  logic                  empty;
  logic                  accept;
  sips_ctl_t             ctl;
  logic signed [EXT_W-1:0] value_ext;
  logic signed [EXT_W-1:0] top_ext;
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DEPTH-1:0]      les;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign value_ext = EXT_W'(value);
  assign din       = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = ST_OK;
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ctl.push   = accept;
          count_next = count + CW'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          ctl.pop    = accept;
          count_next = count - CW'(1);
        end
      end
      default: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_entry;
    logic                  prev_le;
    logic [DATA_WIDTH-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_entry = din;
      assign prev_le    = 1'b1;
    end else begin : g_mid
      assign prev_entry = entries[i-1];
      assign prev_le    = les[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    sips_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CW'(i) < count),
      .din       (din),
      .prev_entry(prev_entry),
      .prev_le   (prev_le),
      .next_entry(next_entry),
      .entry     (entries[i]),
      .le        (les[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign top_ext    = empty ? '0 : EXT_W'($signed(entries[0]));
  assign top_value  = top_ext[FIELD_W-1:0];
  assign item_count = count;
  assign is_empty   = empty;

endmodule

[test/tb_sorted_insert_priority_stack.sv]
// Testbench for sorted_insert_priority_stack: directed and random push, pop and
// read items with a built-in predictor and an in-order result check.
// Depends on sips_pkg and the sorted_insert_priority_stack RTL.
module tb_sorted_insert_priority_stack;
  import sips_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS    = 16;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int WDOG_MAX = 2000;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [FIELD_W-1:0] value;
    int unsigned               gap_pct;
    bit                        drain_first;
  } stack_op_t;

  typedef struct {
    logic signed [FIELD_W-1:0] top_value;
    logic [CNT_W-1:0]          item_count;
    logic                      is_empty;
    logic [STATUS_W-1:0]       status;
  } stack_report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [MODE_W-1:0]         mode = MODE_READ;
  logic signed [FIELD_W-1:0] value = '0;
  logic                      busy;
  logic                      done;
  logic signed [FIELD_W-1:0] top_value;
  logic [CNT_W-1:0]          item_count;
  logic                      is_empty;
  logic [STATUS_W-1:0]       status;

  stack_op_t     op_q[$];
  stack_report_t report_q[$];

  logic signed [FIELD_W-1:0] sorted_slots[SLOTS];
  int                        fill;
  int                        items_taken = 0;
  int                        results_seen = 0;
  int                        n_items;
  int                        errors = 0;
  int                        idle_cycles = 0;

  sorted_insert_priority_stack #(
    .DEPTH(SLOTS),
    .DATA_WIDTH(FIELD_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .done(done),
    .top_value(top_value),
    .item_count(item_count),
    .is_empty(is_empty),
    .status(status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic stack_report_t apply_op(logic [MODE_W-1:0] m,
                                             logic signed [FIELD_W-1:0] v);
    stack_report_t r;
    int pos;
    r.status = ST_OK;
    if (m == MODE_PUSH) begin
      if (fill >= SLOTS) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < fill && sorted_slots[pos] <= v) pos++;
        for (int i = fill; i > pos; i--) sorted_slots[i] = sorted_slots[i-1];
        sorted_slots[pos] = v;
        fill++;
      end
    end else if (m == MODE_POP) begin
      if (fill == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        for (int i = 0; i + 1 < fill; i++) sorted_slots[i] = sorted_slots[i+1];
        fill--;
      end
    end else if (fill == 0) begin
      r.status = ST_UNDERFLOW;
    end
    r.top_value  = (fill != 0) ? sorted_slots[0] : '0;
    r.item_count = CNT_W'(fill);
    r.is_empty   = (fill == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [FIELD_W-1:0] exp_v,
                             logic [FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ERROR %s expected %0h got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic      take;
    logic      go;
    stack_op_t nxt;
    if (rst) begin
      start <= 1'b0;
      fill = 0;
    end else begin
      take = start && !busy;
      if (take) begin
        report_q.insert(report_q.size(), apply_op(mode, value));
        items_taken <= items_taken + 1;
      end
      if (!(start && !take)) begin
        go = 1'b0;
        if (op_q.size() > 0) begin
          nxt = op_q[0];
          if ((!nxt.drain_first || (items_taken == results_seen && !take)) &&
              $urandom_range(99) >= nxt.gap_pct) begin
            go = 1'b1;
          end
        end
        if (go) begin
          void'(op_q.pop_front());
          mode  <= nxt.mode;
          value <= nxt.value;
        end
        start <= go;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_report_t exp_r;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (report_q.size() == 0) begin
        $display("%0t ERROR unexpected result top_value %0h", $time, top_value);
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        check_field("top_value", exp_r.top_value, top_value);
        check_field("item_count", FIELD_W'(exp_r.item_count), FIELD_W'(item_count));
        check_field("is_empty", FIELD_W'(exp_r.is_empty), FIELD_W'(is_empty));
        check_field("status", FIELD_W'(exp_r.status), FIELD_W'(status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_op(logic [MODE_W-1:0] m, logic signed [FIELD_W-1:0] v,
                        int unsigned gap, bit drain);
    stack_op_t op;
    op.mode        = m;
    op.value       = v;
    op.gap_pct     = gap;
    op.drain_first = drain;
    op_q.insert(op_q.size(), op);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(15)) - 8;
      2: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return ($urandom & 32'h8000_0000) | ($urandom >> $urandom_range(31));
    endcase
  endfunction

  initial begin
    int unsigned gaps[3];
    int unsigned push_pct;
    int unsigned burst;
    int          r;
    logic [MODE_W-1:0] m;

    gaps = '{35, 48, 0};

    add_op(MODE_READ, 32'sd0, 0, 1'b0);
    add_op(MODE_POP, 32'sd0, 0, 1'b0);
    add_op(MODE_SPARE, 32'sd0, 0, 1'b0);
    add_op(MODE_PUSH, 32'sh7fff_ffff, 0, 1'b0);
    add_op(MODE_PUSH, 32'sh8000_0000, 0, 1'b0);
    add_op(MODE_PUSH, 32'sd0, 0, 1'b0);
    add_op(MODE_PUSH, -32'sd1, 0, 1'b0);
    add_op(MODE_PUSH, -32'sd1, 0, 1'b0);
    add_op(MODE_PUSH, 32'sh7fff_ffff, 0, 1'b0);
    add_op(MODE_SPARE, 32'sd0, 0, 1'b0);
    add_op(MODE_POP, 32'sd0, 0, 1'b0);
    add_op(MODE_READ, 32'sd0, 0, 1'b0);
    for (int i = 0; i < 10; i++) add_op(MODE_PUSH, $signed(i) - 5, 0, 1'b0);
    add_op(MODE_PUSH, 32'sd1, 0, 1'b0);
    add_op(MODE_READ, 32'sd0, 0, 1'b0);

    for (int p = 0; p < 3; p++) begin
      r = 0;
      while (r < 612) begin
        burst = $urandom_range(60, 20);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
        for (int k = 0; k < burst && r < 612; k++) begin
          if ($urandom_range(99) < push_pct) begin
            m = MODE_PUSH;
          end else begin
            case ($urandom_range(19))
              0: m = MODE_SPARE;
              1, 2, 3, 4: m = MODE_READ;
              default: m = MODE_POP;
            endcase
          end
          add_op(m, pick_value(), gaps[p], (r == 0) || (r % 200 == 100));
          r++;
        end
      end
    end
    n_items = op_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (items_taken == n_items);
    wait (results_seen == items_taken);
    repeat (5) @(posedge clk);
    #1;
    if (report_q.size() != 0) begin
      $display("%0t ERROR %0d expected results never arrived", $time, report_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
